@@ rtl/core/cis_pkg.sv @@
// ----------------------------------------------------------------------------
// Case-insensitive search package
// Shared constants, register indexes and the letter folding function.
// ----------------------------------------------------------------------------
`default_nettype none

package cis_pkg;

   // Default sizing of the search
   localparam int MAX_PATTERN_LEN_DEF = 16;
   localparam int POSITION_BITS_DEF   = 16;

   // Fixed field widths
   localparam int BYTE_W         = 8;
   localparam int OUT_POS_W      = 16;
   localparam int COUNT_W        = 16;
   localparam int CFG_LEN_W      = 5;
   localparam int BYTES_PER_WORD = 8;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 48;
   localparam int RSP_USER_W     = 1;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd2;

   // Character codes used by the folding
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;

   // Fold A to Z to lower case; leave every other code alone
   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = BYTE_W'(b - CHAR_UPPER_A + CHAR_LOWER_A);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cis_match.sv @@
// ----------------------------------------------------------------------------
// Window compare
// Compares the newest pattern-length bytes of the text window against the
// folded pattern, one lane per window position.
// ----------------------------------------------------------------------------
`default_nettype none

module cis_match #(
   parameter int MAX_LEN = cis_pkg::MAX_PATTERN_LEN_DEF,
   parameter int LEN_W   = $clog2(MAX_LEN + 1),
   parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  wire logic [MAX_LEN-1:0][cis_pkg::BYTE_W-1:0] window,   // newest in entry 0
   input  wire logic [MAX_LEN-1:0][cis_pkg::BYTE_W-1:0] pattern,  // folded, byte 0 first
   input  wire logic [LEN_W-1:0]                        len,
   output logic                                         same
);

   logic [MAX_LEN-1:0] lane_ok;

   // Window entry j pairs with pattern byte len-1-j; lanes past len always pass
   for (genvar j = 0; j < MAX_LEN; j++) begin : g_lane
      logic [IDX_W-1:0] sel;
      assign sel = IDX_W'(len - LEN_W'(j) - LEN_W'(1));
      assign lane_ok[j] = (LEN_W'(j) >= len) ||
                          (window[j] == pattern[sel]);
   end

   assign same = &lane_ok;

endmodule

`default_nettype wire

@@ rtl/core/case_insensitive_substring_search_top.sv @@
// ----------------------------------------------------------------------------
// Case-insensitive substring search
// Request path: an accepted request passes the input register, then the result
//   register, before rsp_tvalid rises. Throughput: 1 text byte per cycle unless
//   rsp_tready stalls, set by the combinational window compare and position update.
// Reset: synchronous, active high; pattern length 1, pattern bytes zero,
//   search state cleared. No clearing pass; requests are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_substring_search_top #(
   parameter int MAX_PATTERN_LEN = cis_pkg::MAX_PATTERN_LEN_DEF,
   parameter int POSITION_BITS   = cis_pkg::POSITION_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   // Text requests
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [cis_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] text_byte
   input  wire logic                               req_tlast,   // text_end

   // Results, one per request
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [cis_pkg::RSP_DATA_W-1:0]          rsp_tdata,   // [15:0] match_start,
                                                                // [31:16] match_end,
                                                                // [47:32] match_total
   output logic [cis_pkg::RSP_USER_W-1:0]          rsp_tuser,   // [0] match_hit
   output logic                                    rsp_tlast,   // done_res

   // Configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cis_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [cis_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam int PB    = POSITION_BITS;
   localparam int BW    = cis_pkg::BYTE_W;
   localparam int CW    = cis_pkg::COUNT_W;
   localparam int OW    = cis_pkg::OUT_POS_W;

   localparam logic [PB-1:0] POS_MAX = '1;
   localparam logic [CW-1:0] CNT_MAX = '1;

   // ------------------------------------------------------------------------
   // Configuration: length is clamped to 1..MAX_PATTERN_LEN on write and the
   // pattern bytes are stored already folded.
   // ------------------------------------------------------------------------
   logic [LEN_W-1:0]                      len_ff, len_in;
   logic [MAX_PATTERN_LEN-1:0][BW-1:0]    pat_ff, pat_in;
   logic                                  csr_fire;
   logic [cis_pkg::CFG_LEN_W-1:0]         raw_len;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign raw_len   = csr_wdata[cis_pkg::CFG_LEN_W-1:0];

   always_comb begin
      len_in = len_ff;
      if (csr_fire && csr_index == cis_pkg::CSR_PATTERN_LENGTH) begin
         if (raw_len == '0) begin
            len_in = LEN_W'(1);
         end else if (raw_len > cis_pkg::CFG_LEN_W'(MAX_PATTERN_LEN)) begin
            len_in = LEN_W'(MAX_PATTERN_LEN);
         end else begin
            len_in = LEN_W'(raw_len);
         end
      end
   end

   // Bytes 0..7 come from the low word, 8..15 from the high word
   for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_pat
      if (k < cis_pkg::BYTES_PER_WORD) begin : g_low
         assign pat_in[k] = (csr_fire && csr_index == cis_pkg::CSR_PATTERN_LOW) ?
                            cis_pkg::fold_case(csr_wdata[k*BW +: BW]) : pat_ff[k];
      end else begin : g_high
         assign pat_in[k] = (csr_fire && csr_index == cis_pkg::CSR_PATTERN_HIGH) ?
                            cis_pkg::fold_case(
                               csr_wdata[(k - cis_pkg::BYTES_PER_WORD)*BW +: BW]) :
                            pat_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         pat_ff <= '0;
      end else begin
         len_ff <= len_in;
         pat_ff <= pat_in;
      end
   end

   // ------------------------------------------------------------------------
   // Input register: hold the folded byte and the end flag.
   // ------------------------------------------------------------------------
   logic            s1_valid_ff, s1_valid_in;
   logic [BW-1:0]   s1_byte_ff, s1_byte_in;
   logic            s1_last_ff, s1_last_in;
   logic            req_fire;
   logic            s2_ready;     // result register can take a new value
   logic            s2_load;      // stage 1 moves into the result register

   assign s2_ready   = !rsp_tvalid || rsp_tready;
   assign s2_load    = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = cis_pkg::fold_case(req_tdata[BW-1:0]);
         s1_last_in  = req_tlast;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

   // ------------------------------------------------------------------------
   // Search state and result stage. Window entries past bytes_seen are never
   // compared, so the window needs no reset.
   // ------------------------------------------------------------------------
   logic [MAX_PATTERN_LEN-1:0][BW-1:0] win_ff, win_in;
   logic [PB-1:0]                      seen_ff, seen_in;
   logic [PB-1:0]                      earliest_ff, earliest_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;

   logic [PB-1:0]                      pos;
   logic [PB-1:0]                      start_pos;
   logic                               win_same;
   logic                               hit;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_hit_ff, rsp_hit_in;
   logic [OW-1:0]                      rsp_start_ff, rsp_start_in;
   logic [OW-1:0]                      rsp_end_ff, rsp_end_in;
   logic [CW-1:0]                      rsp_total_ff, rsp_total_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Shift the new byte in at the newest end
   always_comb begin
      win_in = win_ff;
      if (s2_load) begin
         win_in[0] = s1_byte_ff;
         for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
            win_in[i] = win_ff[i-1];
         end
      end
   end

   // Compare against the window as it stands after this byte
   cis_match #(
      .MAX_LEN (MAX_PATTERN_LEN),
      .LEN_W   (LEN_W)
   ) u_match (
      .window  (win_in),
      .pattern (pat_ff),
      .len     (len_ff),
      .same    (win_same)
   );

   // Position of this byte, held at the top once saturated
   assign pos       = (seen_ff == POS_MAX) ? seen_ff : PB'(seen_ff + PB'(1));
   assign start_pos = PB'(pos - PB'(len_ff) + PB'(1));
   assign hit       = (pos >= PB'(len_ff)) && win_same && (start_pos >= earliest_ff);

   always_comb begin
      seen_in     = seen_ff;
      earliest_in = earliest_ff;
      cnt_in      = cnt_ff;
      if (s2_load) begin
         seen_in = pos;
         if (hit) begin
            earliest_in = (pos == POS_MAX) ? POS_MAX : PB'(pos + PB'(1));
            cnt_in      = (cnt_ff == CNT_MAX) ? cnt_ff : CW'(cnt_ff + CW'(1));
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_start_in = hit ? OW'(start_pos) : '0;
         rsp_end_in   = hit ? OW'(pos) : '0;
         rsp_total_in = cnt_in;
         rsp_last_in  = s1_last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         earliest_ff  <= PB'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the search state after the final byte
         if (s2_load && s1_last_ff) begin
            seen_ff     <= '0;
            earliest_ff <= PB'(1);
            cnt_ff      <= '0;
         end else begin
            seen_ff     <= seen_in;
            earliest_ff <= earliest_in;
            cnt_ff      <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff       <= win_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_end_ff, rsp_start_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // The lowest allowed start is a 1-based position and never zero
   a_earliest_nonzero: assert property (@(posedge clock) disable iff (reset)
      earliest_ff != '0)
      else $error("earliest allowed start is zero");

   // The final byte leaves the search state cleared
   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_last_ff) |=>
         (seen_ff == '0 && cnt_ff == '0 && earliest_ff == PB'(1)))
      else $error("search state not cleared after final byte");

   // Within a text the match count never goes down
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s2_load && !s1_last_ff) |=> (cnt_ff >= $past(cnt_ff)))
      else $error("match count decreased");

   // Without a byte entering the result stage the search state holds
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s2_load |=> ($stable(seen_ff) && $stable(cnt_ff) && $stable(earliest_ff)))
      else $error("search state changed without a byte");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-insensitive substring search testbench
// Streams text bytes into the search block and compares every result with a
// behavioral predictor of the leftmost, non-overlapping match search. Directed
// tests cover reset defaults, case folding, overlap rules and length limits.
// Random texts and a long output stall follow.
// ----------------------------------------------------------------------------

module tb_top;
   import cis_pkg::*;

   localparam int          CLK_PERIOD    = 20;
   localparam int          RESET_CYCLES  = 8;
   localparam int          WINDOW        = 16;
   localparam int unsigned POS_LIMIT     = 65535;
   localparam int unsigned COUNT_LIMIT   = 65535;
   localparam int          MAX_GAP       = 14;
   localparam int          RANDOM_ITEMS  = 190;
   localparam int          STALL_ITEMS   = 80;
   localparam int          STALL_CYCLES  = 300;
   localparam int          DRAIN_CYCLES  = 10;

   // One expected result per text byte
   typedef struct {
      logic                 hit;
      logic [OUT_POS_W-1:0] first_pos;
      logic [OUT_POS_W-1:0] last_pos;
      logic [COUNT_W-1:0]   total;
      logic                 done;
   } match_result_type;

   // Block ports
   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [7:0] text_byte
   logic                   req_tlast;   // text_end
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // [15:0] match_start, [31:16] match_end,
                                        // [47:32] match_total
   logic [RSP_USER_W-1:0]  rsp_tuser;   // [0] match_hit
   logic                   rsp_tlast;   // done_res
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predictor state: folded history, newest in entry 0
   logic [BYTE_W-1:0]      history [WINDOW];
   int unsigned            seen_count;
   int unsigned            next_allowed_start;
   int unsigned            match_count;

   // Mirror of the pattern registers
   logic [CFG_LEN_W-1:0]   cfg_length;
   logic [CSR_DATA_W-1:0]  cfg_low;
   logic [CSR_DATA_W-1:0]  cfg_high;

   match_result_type       pending_matches [$];
   logic [BYTE_W-1:0]      text_buf [$];

   int unsigned            err_count;
   int unsigned            text_bytes_sent;
   bit                     idle_on;
   int unsigned            rsp_wait;
   int unsigned            rsp_hold;

   case_insensitive_substring_search_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Fold only A to Z; every other code passes unchanged
   function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return BYTE_W'(c - CHAR_UPPER_A + CHAR_LOWER_A);
      end
      return c;
   endfunction

   // Clamp the programmed length: zero acts as one, above the maximum as the maximum
   function automatic int unsigned active_length();
      if (cfg_length == 0) begin
         return 1;
      end
      if (cfg_length > MAX_PATTERN_LEN_DEF) begin
         return MAX_PATTERN_LEN_DEF;
      end
      return cfg_length;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned k);
      if (k < BYTES_PER_WORD) begin
         return cfg_low[k*BYTE_W +: BYTE_W];
      end
      return cfg_high[(k-BYTES_PER_WORD)*BYTE_W +: BYTE_W];
   endfunction

   function automatic void clear_search_state();
      for (int i = 0; i < WINDOW; i++) begin
         history[i] = '0;
      end
      seen_count         = 0;
      next_allowed_start = 1;
      match_count        = 0;
   endfunction

   // Advance the search by one text byte and return the result it must produce
   function automatic match_result_type predict_match(input logic [BYTE_W-1:0] text_byte,
                                                      input logic text_end);
      match_result_type r;
      int unsigned      len;
      int unsigned      pos;
      int unsigned      first;
      bit               same;
      len = active_length();
      for (int i = WINDOW - 1; i > 0; i--) begin
         history[i] = history[i-1];
      end
      history[0] = to_lower(text_byte);
      if (seen_count < POS_LIMIT) begin
         seen_count++;
      end
      pos         = seen_count;
      r.hit       = 1'b0;
      r.first_pos = '0;
      r.last_pos  = '0;
      if (pos >= len) begin
         same = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (history[len-1-k] != to_lower(pattern_at(k))) begin
               same = 1'b0;
            end
         end
         first = pos - len + 1;
         // Accept only a match that starts past the end of the previous one
         if (same && first >= next_allowed_start) begin
            r.hit              = 1'b1;
            r.first_pos        = OUT_POS_W'(first);
            r.last_pos         = OUT_POS_W'(pos);
            next_allowed_start = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
            if (match_count < COUNT_LIMIT) begin
               match_count++;
            end
         end
      end
      r.total = COUNT_W'(match_count);
      r.done  = text_end;
      if (text_end) begin
         clear_search_state();
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offer one text byte, after a random gap while idle_on is set; hold it until the block takes it
   task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_matches.push_back(predict_match(b, last));
      text_bytes_sent++;
   endtask

   task automatic send_string(input string s, input bit end_text);
      for (int i = 0; i < s.len(); i++) begin
         send_text_byte(s[i], end_text && (i == s.len() - 1));
      end
   endtask

   task automatic send_text_buf();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_text_byte(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   // Drop the request and wait until every result is back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_PATTERN_LENGTH: cfg_length = value[CFG_LEN_W-1:0];
         CSR_PATTERN_LOW:    cfg_low    = value;
         CSR_PATTERN_HIGH:   cfg_high   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reprogram the pattern only once the block has drained
   task automatic load_pattern(input logic [CFG_LEN_W-1:0] len,
                               input logic [CSR_DATA_W-1:0] low,
                               input logic [CSR_DATA_W-1:0] high);
      wait_idle();
      write_csr(CSR_PATTERN_LENGTH, CSR_DATA_W'(len));
      write_csr(CSR_PATTERN_LOW, low);
      write_csr(CSR_PATTERN_HIGH, high);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Count down a forced hold first, then the per-result wait
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            rsp_hold--;
         end else if (rsp_wait > 0) begin
            rsp_tready = 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         err_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, what, want, got);
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            err_count++;
            $display("%0t ns: unexpected result, expected none, actual %h/%h/%h",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_matches.pop_front();
            check_field("match_hit", 16'(want.hit), 16'(rsp_tuser[0]));
            check_field("match_start", want.first_pos, rsp_tdata[15:0]);
            check_field("match_end", want.last_pos, rsp_tdata[31:16]);
            check_field("match_total", want.total, rsp_tdata[47:32]);
            check_field("done_res", 16'(want.done), 16'(rsp_tlast));
         end
         rsp_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
   end

   // ------------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------------

   // Mostly letters, some codes at or just outside the edges of A..Z and a..z
   function automatic logic [BYTE_W-1:0] random_pattern_char();
      logic [BYTE_W-1:0] edges [8];
      int unsigned       r;
      edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h41, 8'h5A, 8'h61, 8'h7A};
      r = $urandom_range(0, 9);
      if (r < 5) begin
         return BYTE_W'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A)
                        + $urandom_range(0, 25));
      end
      if (r < 7) begin
         return edges[$urandom_range(0, 7)];
      end
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Pick upper or lower case at random for a letter
   function automatic logic [BYTE_W-1:0] random_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] lower;
      lower = to_lower(c);
      if (lower >= CHAR_LOWER_A && lower <= CHAR_LOWER_A + 25 && $urandom_range(0, 1)) begin
         return BYTE_W'(lower - CHAR_LOWER_A + CHAR_UPPER_A);
      end
      return lower;
   endfunction

   task automatic randomize_pattern();
      logic [CSR_DATA_W-1:0] low;
      logic [CSR_DATA_W-1:0] high;
      logic [CFG_LEN_W-1:0]  len;
      int unsigned           r;
      low  = {$urandom, $urandom};
      high = {$urandom, $urandom};
      r    = $urandom_range(0, 9);
      if (r < 6) begin
         len = CFG_LEN_W'($urandom_range(1, 5));
      end else if (r < 8) begin
         len = CFG_LEN_W'($urandom_range(6, 16));
      end else if (r == 8) begin
         len = '0;
      end else begin
         len = CFG_LEN_W'($urandom_range(17, 31));
      end
      // Leave the unused upper bytes as noise now and then
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < 2 * BYTES_PER_WORD; k++) begin
            if (k < BYTES_PER_WORD) begin
               low[k*BYTE_W +: BYTE_W] = random_pattern_char();
            end else begin
               high[(k-BYTES_PER_WORD)*BYTE_W +: BYTE_W] = random_pattern_char();
            end
         end
      end
      load_pattern(len, low, high);
   endtask

   // Build a text of pattern copies in mixed case, broken copies and noise
   task automatic send_random_text();
      int unsigned len;
      int unsigned pieces;
      int unsigned cut;
      len    = active_length();
      pieces = $urandom_range(1, 6);
      text_buf.delete();
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               for (int k = 0; k < len; k++) begin
                  text_buf.push_back(random_case(pattern_at(k)));
               end
            end
            5, 6: begin
               cut = $urandom_range(1, len);
               for (int k = 0; k < cut; k++) begin
                  text_buf.push_back(random_case(pattern_at(k)));
               end
               if ($urandom_range(0, 1)) begin
                  text_buf[text_buf.size()-1] = BYTE_W'($urandom_range(0, 255));
               end
            end
            7: begin
               repeat ($urandom_range(1, 4)) begin
                  text_buf.push_back(random_case(pattern_at($urandom_range(0, len - 1))));
               end
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  text_buf.push_back(BYTE_W'($urandom_range(0, 255)));
               end
            end
         endcase
      end
      send_text_buf();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset pattern is one zero byte: zero codes hit, 0xFF does not
   task automatic test_reset_pattern();
      idle_on = 1'b1;
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b1);
   endtask

   // Fold letters on both sides; leave the neighbors of A..Z alone
   task automatic test_case_folding();
      load_pattern(5'd3, CSR_DATA_W'("z@Q"), '0);
      send_string("q@Z", 1'b0);
      send_string("Q`z", 1'b1);
   endtask

   // A self-overlapping pattern must not match inside an accepted match
   task automatic test_overlap();
      load_pattern(5'd2, CSR_DATA_W'("aa"), '0);
      send_string("AaAaa", 1'b1);
   endtask

   // Length zero acts as one; lengths past the maximum act as the maximum
   task automatic test_length_limits();
      load_pattern(5'd0, CSR_DATA_W'(8'hFF), '0);
      send_text_byte(8'hFF, 1'b1);
      load_pattern(5'd31, '1, '1);
      for (int i = 0; i < MAX_PATTERN_LEN_DEF; i++) begin
         send_text_byte(8'hFF, i == MAX_PATTERN_LEN_DEF - 1);
      end
   endtask

   task automatic test_random_texts();
      int unsigned goal;
      goal = text_bytes_sent + RANDOM_ITEMS;
      while (text_bytes_sent < goal) begin
         if ($urandom_range(0, 2) == 0) begin
            randomize_pattern();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         send_random_text();
      end
   endtask

   // Stall the result side for a long stretch while requests keep coming
   task automatic test_output_stall();
      int unsigned goal;
      randomize_pattern();
      idle_on = 1'b0;
      @(posedge clock);
      rsp_hold = STALL_CYCLES;
      goal     = text_bytes_sent + STALL_ITEMS;
      while (text_bytes_sent < goal) begin
         send_random_text();
      end
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tlast       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_PATTERN_LENGTH;
      csr_wdata       = '0;
      err_count       = 0;
      text_bytes_sent = 0;
      idle_on         = 1'b1;
      rsp_wait        = 0;
      rsp_hold        = 0;
      cfg_length      = CFG_LEN_W'(1);
      cfg_low         = '0;
      cfg_high        = '0;
      clear_search_state();

      // Hold reset for a fixed number of cycles, then release off the edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_pattern();
      test_case_folding();
      test_overlap();
      test_length_limits();
      test_random_texts();
      test_output_stall();
      test_random_texts();

      // Drain the last results and give the pipeline time to show strays
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("PASS case_insensitive_substring_search_top");
      end else begin
         $display("FAIL case_insensitive_substring_search_top");
      end
      $finish;
   end

   // Stop a hung run well past the slowest legal run time
   initial begin
      #20_000_000;
      $display("FAIL case_insensitive_substring_search_top");
      $finish;
   end

endmodule

@@ case_insensitive_substring_search_top.f @@
rtl/core/cis_pkg.sv
rtl/core/cis_match.sv
rtl/core/case_insensitive_substring_search_top.sv
sim/tb_top.sv
